@@ rtl/efb_pkg.sv @@
// shared constants, beat command type and escape helpers for the escaped frame builder
// no dependencies
package efb_pkg;

  localparam logic [7:0] START_BYTE = 8'h80;
  localparam logic [7:0] END_BYTE   = 8'h81;
  localparam logic [7:0] ESC_BYTE   = 8'h1B;
  localparam logic [7:0] START_SUB  = 8'hE7;
  localparam logic [7:0] END_SUB    = 8'hE8;
  localparam logic [7:0] ESC_SUB    = 8'h00;
  localparam logic [7:0] CHECK_MASK = 8'h7F;

  localparam int CSUM_W = 7;

  // default depth of the command queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // one classified input beat, as handed from front to back
  typedef struct packed {
    logic              start;  // open a frame before the data
    logic [7:0]        data;
    logic              last;   // close the frame after the data
    logic [CSUM_W-1:0] csum;   // checksum to send when last
  } cmd_t;

  function automatic logic is_special(input logic [7:0] b);
    return (b == START_BYTE) || (b == END_BYTE) || (b == ESC_BYTE);
  endfunction

  // second byte of an escape pair
  function automatic logic [7:0] esc_sub(input logic [7:0] b);
    logic [7:0] r;
    r = ESC_SUB;
    if (b == START_BYTE) begin
      r = START_SUB;
    end else if (b == END_BYTE) begin
      r = END_SUB;
    end
    return r;
  endfunction

endpackage

@@ rtl/escaped_frame_builder.sv @@
// top level of the escaped frame builder: front, command queue and back
// depends on efb_pkg, efb_front, efb_queue, efb_back
//
// Byte-stuffing framer with an xor checksum. Each input beat carries one payload
// byte and a flag marking the last byte of a frame. The first byte of a frame is
// preceded by start byte 0x80; each special payload byte is escaped (0x80 -> 1B E7,
// 0x81 -> 1B E8, 0x1B -> 1B 00). After the last byte the running xor of the frame,
// masked to 7 bits, goes out escaped the same way, then end byte 0x81. out_run_last
// marks the final output beat caused by each input beat. An input beat yields one to
// six output beats. The back part emits one byte per cycle while out_stall is low,
// through a single output register, so sustained throughput is set by the escaped
// byte count. The front part classifies a beat in the cycle it is accepted and
// parks it in a command queue (QUEUE_DEPTH entries), so input is taken every cycle
// while the queue has room, even with the output stalled. When idle, an accepted
// beat is written into the queue and then loaded into the output register.
module escaped_frame_builder #(
  parameter int QUEUE_DEPTH = efb_pkg::QUEUE_DEPTH_DEF  // at least 2
) (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_frame_last,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_last
);

  efb_pkg::cmd_t front_cmd;
  efb_pkg::cmd_t head_cmd;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;

  // frame state and checksum live in the front
  efb_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_data_byte  (in_data_byte),
    .in_frame_last (in_frame_last),
    .q_full        (q_full),
    .in_stall      (in_stall),
    .push          (push),
    .cmd           (front_cmd)
  );

  // decouples input acceptance from output byte expansion
  efb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (front_cmd),
    .pop   (pop),
    .dout  (head_cmd),
    .full  (q_full),
    .empty (q_empty)
  );

  // walks the head command's bytes, popping it as its last byte is loaded
  efb_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .cmd          (head_cmd),
    .out_stall    (out_stall),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_byte     (out_byte),
    .out_run_last (out_run_last)
  );

endmodule

@@ rtl/efb_front.sv @@
// front part: accepts input beats, tracks the open frame and running xor, builds commands
// depends on efb_pkg
module efb_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [7:0]        in_data_byte,
  input  logic              in_frame_last,
  input  logic              q_full,
  output logic              in_stall,
  output logic              push,
  output efb_pkg::cmd_t     cmd
);

  logic       in_frame_r, in_frame_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] xor_sum;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;
  assign xor_sum  = xor_r ^ in_data_byte;

  always_comb begin
    cmd.start = !in_frame_r;
    cmd.data  = in_data_byte;
    cmd.last  = in_frame_last;
    cmd.csum  = xor_sum[efb_pkg::CSUM_W-1:0];
  end

  always_comb begin
    in_frame_nxt = in_frame_r;
    xor_nxt      = xor_r;
    if (push) begin
      if (in_frame_last) begin
        in_frame_nxt = 1'b0;
        xor_nxt      = 8'h00;
      end else begin
        in_frame_nxt = 1'b1;
        xor_nxt      = xor_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      xor_r      <= 8'h00;
    end else begin
      in_frame_r <= in_frame_nxt;
      xor_r      <= xor_nxt;
    end
  end

endmodule

@@ rtl/efb_queue.sv @@
// short command queue between front and back
// depends on efb_pkg
module efb_queue #(
  parameter int DEPTH = efb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  efb_pkg::cmd_t din,
  input  logic          pop,
  output efb_pkg::cmd_t dout,
  output logic          full,
  output logic          empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  efb_pkg::cmd_t mem_r [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

@@ rtl/efb_back.sv @@
// back part: expands one command into its escaped output bytes, one per cycle while out_stall is low
// depends on efb_pkg
module efb_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  efb_pkg::cmd_t cmd,
  input  logic          out_stall,
  output logic          pop,
  output logic          out_valid,
  output logic [7:0]    out_byte,
  output logic          out_run_last
);

  localparam int NPH = 6;
  localparam logic [2:0] PH_START     = 3'd0;
  localparam logic [2:0] PH_DATA_HEAD = 3'd1;
  localparam logic [2:0] PH_DATA_TAIL = 3'd2;
  localparam logic [2:0] PH_CSUM_HEAD = 3'd3;
  localparam logic [2:0] PH_CSUM_TAIL = 3'd4;
  localparam logic [2:0] PH_END       = 3'd5;

  logic [NPH-1:0] done_r, done_nxt;
  logic [NPH-1:0] mask, remaining, sel;
  logic [2:0]     phase;
  logic [7:0]     csum_byte;
  logic [7:0]     byte_sel;
  logic           is_last;
  logic           load, emit;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_run_last_r, out_run_last_nxt;

  assign csum_byte = {1'b0, cmd.csum};

  // which bytes this command produces
  always_comb begin
    mask[PH_START]     = cmd.start;
    mask[PH_DATA_HEAD] = 1'b1;
    mask[PH_DATA_TAIL] = efb_pkg::is_special(cmd.data);
    mask[PH_CSUM_HEAD] = cmd.last;
    mask[PH_CSUM_TAIL] = cmd.last && efb_pkg::is_special(csum_byte);
    mask[PH_END]       = cmd.last;
  end

  assign remaining = mask & ~done_r;
  assign sel       = remaining & (~remaining + 1'b1);
  assign is_last   = (remaining == sel);

  always_comb begin
    priority if (remaining[PH_START]) begin
      phase = PH_START;
    end else if (remaining[PH_DATA_HEAD]) begin
      phase = PH_DATA_HEAD;
    end else if (remaining[PH_DATA_TAIL]) begin
      phase = PH_DATA_TAIL;
    end else if (remaining[PH_CSUM_HEAD]) begin
      phase = PH_CSUM_HEAD;
    end else if (remaining[PH_CSUM_TAIL]) begin
      phase = PH_CSUM_TAIL;
    end else begin
      phase = PH_END;
    end
  end

  always_comb begin
    unique case (phase)
      PH_START: begin
        byte_sel = efb_pkg::START_BYTE;
      end
      PH_DATA_HEAD: begin
        byte_sel = efb_pkg::is_special(cmd.data) ? efb_pkg::ESC_BYTE : cmd.data;
      end
      PH_DATA_TAIL: begin
        byte_sel = efb_pkg::esc_sub(cmd.data);
      end
      PH_CSUM_HEAD: begin
        byte_sel = efb_pkg::is_special(csum_byte) ? efb_pkg::ESC_BYTE : csum_byte;
      end
      PH_CSUM_TAIL: begin
        byte_sel = efb_pkg::esc_sub(csum_byte);
      end
      default: begin
        byte_sel = efb_pkg::END_BYTE;
      end
    endcase
  end

  // output register takes a new beat when empty or drained
  assign load = !out_valid_r || !out_stall;
  assign emit = load && !q_empty;
  assign pop  = emit && is_last;

  always_comb begin
    done_nxt         = done_r;
    out_valid_nxt    = out_valid_r;
    out_byte_nxt     = out_byte_r;
    out_run_last_nxt = out_run_last_r;
    if (load) begin
      out_valid_nxt = emit;
    end
    if (emit) begin
      out_byte_nxt     = byte_sel;
      out_run_last_nxt = is_last;
      done_nxt         = is_last ? '0 : (done_r | sel);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r     <= out_byte_nxt;
    out_run_last_r <= out_run_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_run_last = out_run_last_r;

endmodule
